[rtl/eh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eh_pkg: equal-width histogram shared definitions
// Item and result types, command/status bundles, kind and status codes.
// ----------------------------------------------------------------------------
package eh_pkg;

    localparam int MAX_BINS_DEF   = 256;
    localparam int COUNT_BITS_DEF = 32;

    localparam int SAMPLE_W  = 32;
    localparam int DIV_STEPS = SAMPLE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_CLAMP = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic [7:0]                 read_bin;
    } t_item;

    typedef struct packed {
        logic [7:0]  bin;
        logic [31:0] count;
        logic [1:0]  status;
    } t_result;

    typedef struct packed {
        logic       accept;
        logic       div_load;
        logic       div_step;
        logic       idx_load;
        logic       mem_rd;
        logic       upd;
        logic       clr_step;
        logic       res_zero;
        logic [1:0] res_status;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_kind;
        logic       below;
        logic       div_done;
        logic       clr_done;
    } t_sts;

endpackage
`default_nettype wire

[rtl/eh_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eh_dp: histogram datapath
// Offset subtract, serial restoring divider, bin clamp, counter memory with
// read-modify-write and clearing sweep, result and output registers.
// ----------------------------------------------------------------------------
module eh_dp #(
    parameter int MAX_BINS   = eh_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = eh_pkg::COUNT_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic signed [31:0]           i_range_start,
    input  wire logic [31:0]                  i_bin_width,
    input  wire logic [8:0]                   i_bin_count,
    input  wire eh_pkg::t_item                i_item,
    input  wire eh_pkg::t_cmd                 i_cmd,
    output eh_pkg::t_sts                      o_sts,
    output eh_pkg::t_result                   o_result
);

    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int NB_W  = (BIN_W + 1 > 9) ? BIN_W + 1 : 9;
    localparam int CMP_W = (BIN_W + 1 > 8) ? BIN_W + 1 : 8;

    logic [COUNT_BITS-1:0] r_mem [MAX_BINS];

    logic [1:0]                  r_kind;
    logic [7:0]                  r_rb;
    logic [32:0]                 r_diff;
    logic [31:0]                 r_div;
    logic [31:0]                 r_rem;
    logic [31:0]                 r_quo;
    logic [eh_pkg::DIV_CNT_W-1:0] r_step;
    logic [BIN_W-1:0]            r_idx;
    logic                        r_clamp;
    logic [BIN_W-1:0]            r_clr_addr;
    logic [COUNT_BITS-1:0]       r_rdata;
    eh_pkg::t_result             r_res;
    eh_pkg::t_result             r_out;

    logic [32:0]           shifted;
    logic [32:0]           trial;
    logic [NB_W-1:0]       bc_ext;
    logic [NB_W-1:0]       n_used;
    logic                  clamp;
    logic                  sat;
    logic [COUNT_BITS-1:0] new_count;
    logic                  rb_ok;
    logic                  clr_done;
    logic [BIN_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [BIN_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    assign shifted = {r_rem, r_quo[31]};
    assign trial   = shifted - {1'b0, r_div};

    assign bc_ext = NB_W'(i_bin_count);
    always_comb begin
        if (bc_ext == '0) begin
            n_used = NB_W'(1);
        end else if (bc_ext > NB_W'(MAX_BINS)) begin
            n_used = NB_W'(MAX_BINS);
        end else begin
            n_used = bc_ext;
        end
    end
    assign clamp = (r_quo >= 32'(n_used));

    assign sat       = &r_rdata;
    assign new_count = sat ? r_rdata : r_rdata + COUNT_BITS'(1);
    assign rb_ok     = (CMP_W'(r_rb) < CMP_W'(MAX_BINS));
    assign clr_done  = (r_clr_addr == BIN_W'(MAX_BINS - 1));

    assign rd_addr = (r_kind == eh_pkg::KIND_SAMPLE) ? r_idx : BIN_W'(r_rb);
    assign mem_we  = i_cmd.clr_step || (i_cmd.upd && (r_kind == eh_pkg::KIND_SAMPLE));
    assign wr_addr = i_cmd.clr_step ? r_clr_addr : r_idx;
    assign wr_data = i_cmd.clr_step ? '0 : new_count;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= clr_done ? '0 : r_clr_addr + BIN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_item.kind;
            r_rb   <= i_item.read_bin;
            r_diff <= {i_item.sample[31], i_item.sample} - {i_range_start[31], i_range_start};
        end
        if (i_cmd.div_load) begin
            r_div  <= (i_bin_width == '0) ? 32'd1 : i_bin_width;
            r_rem  <= '0;
            r_quo  <= r_diff[31:0];
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            if (!trial[32]) begin
                r_rem <= trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= shifted[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
            r_step <= r_step + eh_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.idx_load) begin
            r_clamp <= clamp;
            r_idx   <= clamp ? BIN_W'(n_used - NB_W'(1)) : r_quo[BIN_W-1:0];
        end
        if (i_cmd.res_zero) begin
            r_res.bin    <= '0;
            r_res.count  <= '0;
            r_res.status <= i_cmd.res_status;
        end else if (i_cmd.upd) begin
            if (r_kind == eh_pkg::KIND_SAMPLE) begin
                r_res.bin    <= 8'(r_idx);
                r_res.count  <= 32'(new_count);
                r_res.status <= sat ? eh_pkg::ST_SAT :
                                (r_clamp ? eh_pkg::ST_CLAMP : eh_pkg::ST_OK);
            end else begin
                r_res.bin    <= r_rb;
                r_res.count  <= rb_ok ? 32'(r_rdata) : 32'd0;
                r_res.status <= eh_pkg::ST_OK;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_sts.in_kind  = i_item.kind;
    assign o_sts.below    = r_diff[32];
    assign o_sts.div_done = (r_step == eh_pkg::DIV_CNT_W'(eh_pkg::DIV_STEPS - 1));
    assign o_sts.clr_done = clr_done;
    assign o_result       = r_out;

endmodule
`default_nettype wire

[rtl/eh_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eh_ctrl: histogram controller
// Sequences clearing sweeps, the serial divide, the counter update and the
// output handshake.
// ----------------------------------------------------------------------------
module eh_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    input  wire eh_pkg::t_sts i_sts,
    output eh_pkg::t_cmd      o_cmd
);

    typedef enum logic [8:0] {
        S_INIT = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_PREP = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_IDX  = 9'b000010000,
        S_RD   = 9'b000100000,
        S_UPD  = 9'b001000000,
        S_CLR  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_sts.in_kind)
                        eh_pkg::KIND_SAMPLE: n_state = S_PREP;
                        eh_pkg::KIND_READ:   n_state = S_RD;
                        eh_pkg::KIND_CLEAR:  n_state = S_CLR;
                        default: begin
                            o_cmd.res_zero   = 1'b1;
                            o_cmd.res_status = eh_pkg::ST_OK;
                            n_state          = S_DONE;
                        end
                    endcase
                end
            end
            S_PREP: begin
                if (i_sts.below) begin
                    o_cmd.res_zero   = 1'b1;
                    o_cmd.res_status = eh_pkg::ST_BELOW;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                o_cmd.idx_load = 1'b1;
                n_state        = S_RD;
            end
            S_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DONE;
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    o_cmd.res_zero   = 1'b1;
                    o_cmd.res_status = eh_pkg::ST_OK;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

[rtl/equal_width_histogram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// equal_width_histogram: equal-width binning histogram engine
// Bins signed samples into saturating counters, reads and clears bins.
// ----------------------------------------------------------------------------
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken. A sample item passes through one
// offset subtract, 32 steps of the serial restoring divider, bin clamp, a
// registered counter read, the write back, and the result load. A sample
// below range_start skips the divide, a read item goes to the counter read,
// an unused kind goes to the result load, and a clear item runs the sweep
// that zeroes one counter per cycle through the memory write port. After reset
// the same sweep runs with o_in_ready low; register writes are taken
// throughout. Write registers only while no item is in work.
module equal_width_histogram #(
    parameter int MAX_BINS   = eh_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = eh_pkg::COUNT_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire eh_pkg::t_item   i_in_item,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output eh_pkg::t_result      o_out_item,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [3:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [1:0] REG_RANGE_START = 2'd0;
    localparam logic [1:0] REG_BIN_WIDTH   = 2'd1;
    localparam logic [1:0] REG_BIN_COUNT   = 2'd2;

    logic signed [31:0] r_range_start;
    logic [31:0]        r_bin_width;
    logic [8:0]         r_bin_count;
    logic               cfg_we;

    eh_pkg::t_cmd cmd;
    eh_pkg::t_sts sts;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_start <= '0;
            r_bin_width   <= 32'd1;
            r_bin_count   <= 9'd256;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_RANGE_START: r_range_start <= pwdata;
                REG_BIN_WIDTH:   r_bin_width   <= pwdata;
                REG_BIN_COUNT:   r_bin_count   <= pwdata[8:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_RANGE_START: prdata = r_range_start;
            REG_BIN_WIDTH:   prdata = r_bin_width;
            REG_BIN_COUNT:   prdata = 32'(r_bin_count);
            default:         prdata = '0;
        endcase
    end

    eh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    eh_dp #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_range_start (r_range_start),
        .i_bin_width   (r_bin_width),
        .i_bin_count   (r_bin_count),
        .i_item        (i_in_item),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_result      (o_out_item)
    );

`ifndef NO_ASSERTIONS
    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over a waiting result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> !o_in_ready)
        else $error("ready right after an accepted item");

    a_upd_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.upd |-> $past(cmd.mem_rd))
        else $error("counter update without a prior memory read");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.div_load, cmd.div_step, cmd.idx_load,
                  cmd.mem_rd, cmd.upd, cmd.clr_step, cmd.out_load}))
        else $error("more than one datapath command in a cycle");
`endif

endmodule
`default_nettype wire
